[design/co2_sensor_uart_frame_engine_top_defines.svh]
// Assertion macros shared by the frame engine files.
`ifndef CO2_SENSOR_UART_FRAME_ENGINE_TOP_DEFINES_SVH
`define CO2_SENSOR_UART_FRAME_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Condition now implies consequence in the same cycle.
`define CCFE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccfe check failed");

// Condition now implies consequence in the next cycle.
`define CCFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccfe check failed");

`else

`define CCFE_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CCFE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/ccfe_pkg.sv]
// Shared types, codes and the command frame table of the frame engine.
package ccfe_pkg;

    // Item opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_RX    = 1'b1;

    // Result kinds
    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // Command codes
    localparam logic [3:0] CMD_PPM       = 4'd0;
    localparam logic [3:0] CMD_RANGE_Q   = 4'd1;
    localparam logic [3:0] CMD_ABC_ON    = 4'd2;
    localparam logic [3:0] CMD_ABC_OFF   = 4'd3;
    localparam logic [3:0] CMD_RANGE2000 = 4'd4;
    localparam logic [3:0] CMD_RANGE5000 = 4'd5;
    localparam logic [3:0] CMD_ZERO      = 4'd6;
    localparam logic [3:0] CMD_RESET     = 4'd7;
    localparam logic [3:0] CMD_TEMP      = 4'd8;
    localparam logic [3:0] NUM_CODES     = 4'd9;

    // Frame format
    localparam int         FRAME_LEN     = 9;
    localparam logic [7:0] HEADER_BYTE   = 8'hFF;
    localparam int         PAYLOAD_FIRST = 2;
    localparam int         PAYLOAD_LAST  = 5;

    // Reply constants
    localparam logic signed [8:0]  TEMP_OFFSET = 9'sd44;
    localparam logic [15:0]        RANGE_2000  = 16'd2000;
    localparam logic [15:0]        RANGE_5000  = 16'd5000;
    localparam logic signed [16:0] REPLY_ACK   = 17'sd1;
    localparam logic signed [16:0] REPLY_NONE  = 17'sd0;

    // Receive side status after one step
    typedef struct packed {
        logic               done;
        logic               ok;
        logic signed [16:0] reply;
        logic signed [8:0]  temperature;
        logic [15:0]        sensor_range;
        logic               resync;
    } t_rx_status;

    // Command frame for one code, byte 0 in the top bits
    function automatic logic [8*FRAME_LEN-1:0] frame_row(input logic [3:0] code);
        logic [8*FRAME_LEN-1:0] row;
        row = '0;
        unique case (code)
            CMD_PPM:       row = 72'hFF_01_86_00_00_00_00_00_79;
            CMD_RANGE_Q:   row = 72'hFF_01_9B_00_00_00_00_00_64;
            CMD_ABC_ON:    row = 72'hFF_01_79_A0_00_00_00_00_E6;
            CMD_ABC_OFF:   row = 72'hFF_01_79_00_00_00_00_00_86;
            CMD_RANGE2000: row = 72'hFF_01_99_00_00_00_07_D0_8F;
            CMD_RANGE5000: row = 72'hFF_01_99_00_00_00_13_88_CB;
            CMD_ZERO:      row = 72'hFF_01_87_00_00_00_00_00_78;
            CMD_RESET:     row = 72'hFF_01_78_00_00_00_00_00_87;
            CMD_TEMP:      row = 72'hFF_01_86_00_00_00_00_00_79;
            default:       row = '0;
        endcase
        return row;
    endfunction

endpackage

[design/ccfe_tx_seq.sv]
// Beat sequencer that walks one command frame out of the table.
module ccfe_tx_seq #(
    parameter int FRAME_BYTES = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic [3:0]                    i_code,
    output logic [7:0]                    o_tx_byte,
    output logic                          o_last,
    output logic                          o_mid_frame
);

    localparam int CW = $clog2(FRAME_BYTES);
    localparam logic [CW-1:0] LAST_BEAT = CW'(FRAME_BYTES - 1);

    logic [CW-1:0]                      r_beat;
    logic [CW-1:0]                      n_beat;
    logic [8*ccfe_pkg::FRAME_LEN-1:0]   row;

    // Pick the current byte of the frame
    assign row       = ccfe_pkg::frame_row(i_code);
    assign o_tx_byte = row[8*(ccfe_pkg::FRAME_LEN-1-int'(r_beat)) +: 8];
    assign o_last    = (r_beat == LAST_BEAT);
    assign o_mid_frame = (r_beat != '0) && !o_last;

    // Advance one beat per emitted byte, wrap after the last
    always_comb begin
        n_beat = r_beat;
        if (i_advance) begin
            n_beat = o_last ? '0 : r_beat + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= '0;
        end else begin
            r_beat <= n_beat;
        end
    end

endmodule

[design/ccfe_rx_frame.sv]
// Receive frame checker: counts, sums and decodes reply frames.
module ccfe_rx_frame #(
    parameter int FRAME_BYTES = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    input  logic                  i_start,
    input  logic [3:0]            i_code,
    output ccfe_pkg::t_rx_status  o_status
);

    localparam int CW = $clog2(FRAME_BYTES);
    localparam logic [CW-1:0] LAST_POS = CW'(FRAME_BYTES - 1);
    localparam logic [CW-1:0] P_FIRST  = CW'(ccfe_pkg::PAYLOAD_FIRST);
    localparam logic [CW-1:0] P_LAST   = CW'(ccfe_pkg::PAYLOAD_LAST);

    logic [3:0]         r_pending;
    logic [CW-1:0]      r_count;
    logic [7:0]         r_sum;
    logic               r_header;
    logic [7:0]         r_payload [4];
    logic [15:0]        r_range;
    logic signed [8:0]  r_temp;
    logic               r_resync;

    logic [3:0]         n_pending;
    logic [CW-1:0]      n_count;
    logic [7:0]         n_sum;
    logic               n_header;
    logic [15:0]        n_range;
    logic signed [8:0]  n_temp;
    logic               n_resync;

    logic               at_end;
    logic               frame_ok;
    logic               payload_we;
    logic [1:0]         payload_idx;
    logic [CW-1:0]      idx_full;
    logic signed [8:0]  frame_temp;
    logic [15:0]        word_lo;
    logic [15:0]        word_hi;
    logic signed [16:0] reply;

    assign at_end      = (r_count == LAST_POS);
    assign frame_ok    = r_header && (i_byte == 8'(8'd0 - r_sum));
    assign payload_we  = i_step && (r_count >= P_FIRST) && (r_count <= P_LAST);
    assign idx_full    = r_count - P_FIRST;
    assign payload_idx = idx_full[1:0];
    assign frame_temp  = $signed({1'b0, r_payload[2]}) - ccfe_pkg::TEMP_OFFSET;
    assign word_lo     = {r_payload[0], r_payload[1]};
    assign word_hi     = {r_payload[2], r_payload[3]};

    // Next receive state and kept values
    always_comb begin
        n_pending = r_pending;
        n_count   = r_count;
        n_sum     = r_sum;
        n_header  = r_header;
        n_range   = r_range;
        n_temp    = r_temp;
        n_resync  = r_resync;
        reply     = ccfe_pkg::REPLY_NONE;
        if (i_start) begin
            n_pending = i_code;
            n_count   = '0;
            n_sum     = '0;
            n_header  = 1'b0;
        end else if (i_step) begin
            if (!at_end) begin
                n_count = r_count + CW'(1);
                if (r_count == '0) begin
                    n_header = (i_byte == ccfe_pkg::HEADER_BYTE);
                end else begin
                    n_sum = r_sum + i_byte;
                end
            end else begin
                n_count  = '0;
                n_sum    = '0;
                n_header = 1'b0;
                if (!frame_ok) begin
                    n_resync = 1'b1;
                end else begin
                    unique case (r_pending)
                        ccfe_pkg::CMD_PPM: begin
                            reply  = 17'(word_lo);
                            n_temp = frame_temp;
                        end
                        ccfe_pkg::CMD_RANGE_Q: begin
                            reply = 17'(word_hi);
                            if (word_hi != '0) begin
                                n_resync = 1'b0;
                            end
                        end
                        ccfe_pkg::CMD_RANGE2000: begin
                            reply   = ccfe_pkg::REPLY_ACK;
                            n_range = ccfe_pkg::RANGE_2000;
                        end
                        ccfe_pkg::CMD_RANGE5000: begin
                            reply   = ccfe_pkg::REPLY_ACK;
                            n_range = ccfe_pkg::RANGE_5000;
                        end
                        ccfe_pkg::CMD_TEMP: begin
                            n_temp = frame_temp;
                            reply  = {{8{frame_temp[8]}}, frame_temp};
                        end
                        default: begin
                            reply = ccfe_pkg::REPLY_ACK;
                        end
                    endcase
                end
            end
        end
    end

    // Report status after this step
    always_comb begin
        o_status.done         = i_step && at_end;
        o_status.ok           = frame_ok;
        o_status.reply        = reply;
        o_status.temperature  = n_temp;
        o_status.sensor_range = n_range;
        o_status.resync       = n_resync;
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= ccfe_pkg::CMD_PPM;
            r_count   <= '0;
            r_sum     <= '0;
            r_header  <= 1'b0;
            r_range   <= ccfe_pkg::RANGE_5000;
            r_temp    <= '0;
            r_resync  <= 1'b1;
        end else begin
            r_pending <= n_pending;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_header  <= n_header;
            r_range   <= n_range;
            r_temp    <= n_temp;
            r_resync  <= n_resync;
        end
    end

    // Capture payload bytes two through five
    always_ff @(posedge i_clk) begin
        if (payload_we) begin
            r_payload[payload_idx] <= i_byte;
        end
    end

endmodule

[design/co2_sensor_uart_frame_engine_top.sv]
// Top level of the nine-byte sensor frame engine.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   item in | input     | i_valid / o_stall  | i_opcode, i_command_code, i_rx_byte
//   result  | output    | o_valid / i_stall  | o_kind, o_tx_byte, o_last, o_checksum_ok,
//           |           |                    | o_reply_value, o_temperature,
//           |           |                    | o_sensor_range, o_resync_needed
//
// A received byte passes through the input register and then the result
// register; one byte is taken every cycle while results drain.
// A start request holds the input register until its last table beat has left the
// beat sequencer, one beat per cycle while results drain; unknown codes give no result.
// Synchronous active-low reset clears all control state; no clearing pass.
// A stalled result holds the result register, which then stalls all but unknown codes.
module co2_sensor_uart_frame_engine_top #(
    parameter int FRAME_BYTES = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic [3:0]         i_command_code,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic [7:0]         o_tx_byte,
    output logic               o_last,
    output logic               o_checksum_ok,
    output logic signed [16:0] o_reply_value,
    output logic signed [8:0]  o_temperature,
    output logic [15:0]        o_sensor_range,
    output logic               o_resync_needed
);

    `include "co2_sensor_uart_frame_engine_top_defines.svh"

    logic                 r_in_valid;
    logic                 r_in_op;
    logic [3:0]           r_in_code;
    logic [7:0]           r_in_byte;

    logic                 r_out_valid;
    logic                 r_kind;
    logic [7:0]           r_tx_byte;
    logic                 r_last;
    logic                 r_ok;
    logic signed [16:0]   r_reply;
    logic signed [8:0]    r_temp;
    logic [15:0]          r_range;
    logic                 r_resync;

    logic                 accept;
    logic                 out_free;
    logic                 is_start;
    logic                 code_ok;
    logic                 emit_tx;
    logic                 rx_step;
    logic                 advance;
    logic                 tx_last;
    logic                 tx_mid;
    logic [7:0]           tx_byte;
    ccfe_pkg::t_rx_status rx_status;

    // Handshake and work selection
    assign out_free = !r_out_valid || !i_stall;
    assign is_start = (r_in_op == ccfe_pkg::OP_START);
    assign code_ok  = (r_in_code < ccfe_pkg::NUM_CODES);
    assign emit_tx  = r_in_valid && is_start && code_ok && out_free;
    assign rx_step  = r_in_valid && !is_start && out_free;
    assign advance  = r_in_valid && (is_start ? (!code_ok || (out_free && tx_last))
                                              : out_free);
    assign o_stall  = r_in_valid && !advance;
    assign accept   = i_valid && !o_stall;

    ccfe_tx_seq #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_tx_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (emit_tx),
        .i_code      (r_in_code),
        .o_tx_byte   (tx_byte),
        .o_last      (tx_last),
        .o_mid_frame (tx_mid)
    );

    ccfe_rx_frame #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_rx_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (rx_step),
        .i_byte   (r_in_byte),
        .i_start  (emit_tx && tx_last),
        .i_code   (r_in_code),
        .o_status (rx_status)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_op   <= i_opcode;
            r_in_code <= i_command_code;
            r_in_byte <= i_rx_byte;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_tx || rx_status.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload: a frame beat or a reply
    always_ff @(posedge i_clk) begin
        if (emit_tx) begin
            r_kind    <= ccfe_pkg::KIND_TX;
            r_tx_byte <= tx_byte;
            r_last    <= tx_last;
            r_ok      <= 1'b0;
            r_reply   <= ccfe_pkg::REPLY_NONE;
            r_temp    <= rx_status.temperature;
            r_range   <= rx_status.sensor_range;
            r_resync  <= rx_status.resync;
        end else if (rx_status.done) begin
            r_kind    <= ccfe_pkg::KIND_REPLY;
            r_tx_byte <= '0;
            r_last    <= 1'b0;
            r_ok      <= rx_status.ok;
            r_reply   <= rx_status.reply;
            r_temp    <= rx_status.temperature;
            r_range   <= rx_status.sensor_range;
            r_resync  <= rx_status.resync;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_kind;
    assign o_tx_byte       = r_tx_byte;
    assign o_last          = r_last;
    assign o_checksum_ok   = r_ok;
    assign o_reply_value   = r_reply;
    assign o_temperature   = r_temp;
    assign o_sensor_range  = r_range;
    assign o_resync_needed = r_resync;

    // Checks
    `CCFE_ASSERT_SAME(a_mid_frame_stalls, i_clk, i_rst_n, tx_mid, o_stall && r_in_valid)
    `CCFE_ASSERT_NEXT(a_last_beat_marked, i_clk, i_rst_n, emit_tx && tx_last,
        o_valid && o_last && (o_kind == ccfe_pkg::KIND_TX))
    `CCFE_ASSERT_SAME(a_bad_frame_resync, i_clk, i_rst_n,
        o_valid && (o_kind == ccfe_pkg::KIND_REPLY) && !o_checksum_ok,
        o_resync_needed && (o_reply_value == ccfe_pkg::REPLY_NONE))

endmodule

[tb/sv/tb_co2_sensor_uart_frame_engine_top.sv]
// Self-checking testbench for the nine-byte sensor frame engine.
`timescale 1ns / 100ps

module tb_co2_sensor_uart_frame_engine_top;

    typedef logic [8:0][7:0] t_frame;

    typedef struct packed {
        logic       op;
        logic [3:0] code;
        logic [7:0] data;
    } t_link_item;

    typedef struct packed {
        logic               kind;
        logic [7:0]         tx;
        logic               last;
        logic               ok;
        logic signed [16:0] reply;
        logic signed [8:0]  temp;
        logic [15:0]        sens_range;
        logic               resync;
    } t_out_beat;

    typedef enum int {FRAME_GOOD, FRAME_BAD_HEADER, FRAME_BAD_SUM} t_frame_flaw;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_opcode;
    logic [3:0]         i_command_code;
    logic [7:0]         i_rx_byte;
    logic               o_valid;
    logic               i_stall;
    logic               o_kind;
    logic [7:0]         o_tx_byte;
    logic               o_last;
    logic               o_checksum_ok;
    logic signed [16:0] o_reply_value;
    logic signed [8:0]  o_temperature;
    logic [15:0]        o_sensor_range;
    logic               o_resync_needed;

    // Link items waiting to be driven and result beats still owed by the block
    t_link_item link_items[$];
    t_out_beat  expected_beats[$];

    // Predicted block state
    logic [3:0]         pend_cmd;
    logic [3:0]         rx_count;
    logic [7:0]         rx_sum;
    logic               header_ok;
    logic [7:0]         payload_kept[4];
    logic [15:0]        range_kept;
    logic signed [8:0]  temp_kept;
    logic               resync_kept;

    // Handshake bookkeeping
    t_link_item next_item;
    t_out_beat  got;
    t_out_beat  want;
    int         drv_wait;
    logic       drv_quiet;
    int         rx_hold;
    logic       rx_quiet;
    logic       in_beat_taken;
    int         mismatch_cnt;

    co2_sensor_uart_frame_engine_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_command_code  (i_command_code),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_tx_byte       (o_tx_byte),
        .o_last          (o_last),
        .o_checksum_ok   (o_checksum_ok),
        .o_reply_value   (o_reply_value),
        .o_temperature   (o_temperature),
        .o_sensor_range  (o_sensor_range),
        .o_resync_needed (o_resync_needed)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Build the command frame for one code; the last byte closes the checksum
    function automatic t_frame command_frame(input logic [3:0] code);
        t_frame     f;
        logic [7:0] sum;
        f = '0;
        f[0] = ccfe_pkg::HEADER_BYTE;
        f[1] = 8'h01;
        case (code)
            ccfe_pkg::CMD_PPM, ccfe_pkg::CMD_TEMP: f[2] = 8'h86;
            ccfe_pkg::CMD_RANGE_Q:                 f[2] = 8'h9B;
            ccfe_pkg::CMD_ABC_ON: begin
                f[2] = 8'h79;
                f[3] = 8'hA0;
            end
            ccfe_pkg::CMD_ABC_OFF:                 f[2] = 8'h79;
            ccfe_pkg::CMD_RANGE2000: begin
                f[2] = 8'h99;
                {f[6], f[7]} = ccfe_pkg::RANGE_2000;
            end
            ccfe_pkg::CMD_RANGE5000: begin
                f[2] = 8'h99;
                {f[6], f[7]} = ccfe_pkg::RANGE_5000;
            end
            ccfe_pkg::CMD_ZERO:                    f[2] = 8'h87;
            ccfe_pkg::CMD_RESET:                   f[2] = 8'h78;
            default: ;
        endcase
        sum = 8'd0;
        for (int k = 1; k < ccfe_pkg::FRAME_LEN - 1; k++) sum += f[k];
        f[8] = -sum;
        return f;
    endfunction

    task automatic push_beat(input logic kind, input logic [7:0] tx, input logic last,
                             input logic ok, input logic signed [16:0] reply);
        t_out_beat b;
        b.kind       = kind;
        b.tx         = tx;
        b.last       = last;
        b.ok         = ok;
        b.reply      = reply;
        b.temp       = temp_kept;
        b.sens_range = range_kept;
        b.resync     = resync_kept;
        expected_beats.push_back(b);
    endtask

    // Advance the predicted link state by one accepted item
    task automatic step_sensor_link(input t_link_item it);
        t_frame             f;
        logic [7:0]         want_sum;
        logic               good;
        logic signed [16:0] rep;
        if (it.op == ccfe_pkg::OP_START) begin
            // Drop unknown codes without touching state
            if (it.code >= ccfe_pkg::NUM_CODES) return;
            pend_cmd  = it.code;
            rx_count  = 4'd0;
            rx_sum    = 8'd0;
            header_ok = 1'b0;
            f = command_frame(it.code);
            for (int k = 0; k < ccfe_pkg::FRAME_LEN; k++)
                push_beat(ccfe_pkg::KIND_TX, f[k], k == ccfe_pkg::FRAME_LEN - 1, 1'b0,
                          ccfe_pkg::REPLY_NONE);
            return;
        end

        // Track header, checksum sum and payload bytes
        if (rx_count == 0) begin
            header_ok = (it.data == ccfe_pkg::HEADER_BYTE);
        end else if (rx_count < ccfe_pkg::FRAME_LEN - 1) begin
            rx_sum += it.data;
            if (rx_count >= ccfe_pkg::PAYLOAD_FIRST && rx_count <= ccfe_pkg::PAYLOAD_LAST)
                payload_kept[rx_count - ccfe_pkg::PAYLOAD_FIRST] = it.data;
        end
        if (rx_count < ccfe_pkg::FRAME_LEN - 1) begin
            rx_count++;
            return;
        end

        // Ninth byte: judge the frame and form the reply
        want_sum = -rx_sum;
        good = header_ok && (it.data == want_sum);
        rep = ccfe_pkg::REPLY_NONE;
        if (!good) begin
            resync_kept = 1'b1;
        end else begin
            case (pend_cmd)
                ccfe_pkg::CMD_PPM: begin
                    rep = {1'b0, payload_kept[0], payload_kept[1]};
                    temp_kept = $signed({1'b0, payload_kept[2]}) - ccfe_pkg::TEMP_OFFSET;
                end
                ccfe_pkg::CMD_RANGE_Q: begin
                    rep = {1'b0, payload_kept[2], payload_kept[3]};
                    if (rep != 0) resync_kept = 1'b0;
                end
                ccfe_pkg::CMD_RANGE2000: begin
                    rep = ccfe_pkg::REPLY_ACK;
                    range_kept = ccfe_pkg::RANGE_2000;
                end
                ccfe_pkg::CMD_RANGE5000: begin
                    rep = ccfe_pkg::REPLY_ACK;
                    range_kept = ccfe_pkg::RANGE_5000;
                end
                ccfe_pkg::CMD_TEMP: begin
                    temp_kept = $signed({1'b0, payload_kept[2]}) - ccfe_pkg::TEMP_OFFSET;
                    rep = temp_kept;
                end
                default: rep = ccfe_pkg::REPLY_ACK;
            endcase
        end
        rx_count  = 4'd0;
        rx_sum    = 8'd0;
        header_ok = 1'b0;
        push_beat(ccfe_pkg::KIND_REPLY, 8'd0, 1'b0, good, rep);
    endtask

    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int draw_wait(input logic quiet);
        return quiet ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic string beat_str(input t_out_beat b);
        return $sformatf({"kind=%0d tx=%02h last=%0d ok=%0d reply=%0d ",
                          "temp=%0d range=%0d resync=%0d"},
                         b.kind, b.tx, b.last, b.ok, b.reply, b.temp, b.sens_range, b.resync);
    endfunction

    task automatic queue_start(input logic [3:0] code);
        t_link_item it;
        it.op   = ccfe_pkg::OP_START;
        it.code = code;
        it.data = 8'($urandom_range(0, 255));
        link_items.push_back(it);
    endtask

    task automatic queue_rx(input logic [7:0] data);
        t_link_item it;
        it.op   = ccfe_pkg::OP_RX;
        it.code = 4'($urandom_range(0, 15));
        it.data = data;
        link_items.push_back(it);
    endtask

    // Queue one sensor reply frame, optionally with a broken header or checksum
    task automatic queue_reply_frame(input logic [7:0] b2, input logic [7:0] b3,
                                     input logic [7:0] b4, input logic [7:0] b5,
                                     input t_frame_flaw flaw);
        t_frame     f;
        logic [7:0] sum;
        f[0] = (flaw == FRAME_BAD_HEADER) ? 8'($urandom_range(0, 254))
                                          : ccfe_pkg::HEADER_BYTE;
        f[1] = rand_byte();
        f[2] = b2;
        f[3] = b3;
        f[4] = b4;
        f[5] = b5;
        f[6] = rand_byte();
        f[7] = rand_byte();
        sum = 8'd0;
        for (int k = 1; k < ccfe_pkg::FRAME_LEN - 1; k++) sum += f[k];
        f[8] = -sum;
        if (flaw == FRAME_BAD_SUM) f[8] = f[8] ^ 8'($urandom_range(1, 255));
        for (int k = 0; k < ccfe_pkg::FRAME_LEN; k++) queue_rx(f[k]);
    endtask

    // Driver: present one item per beat, hold it until taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_beat_taken)) begin
            in_beat_taken = 1'b0;
            if (drv_wait > 0) begin
                drv_wait--;
                i_valid <= 1'b0;
            end else if (link_items.size() != 0) begin
                next_item = link_items.pop_front();
                i_opcode       <= next_item.op;
                i_command_code <= next_item.code;
                i_rx_byte      <= next_item.data;
                i_valid        <= 1'b1;
                if ($urandom_range(0, 15) == 0) drv_quiet = !drv_quiet;
                drv_wait = draw_wait(drv_quiet);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result side: hold stall for the drawn number of cycles
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_stall <= 1'b1;
            rx_hold--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: check result beats first, then predict from the accepted item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got.kind       = o_kind;
                got.tx         = o_tx_byte;
                got.last       = o_last;
                got.ok         = o_checksum_ok;
                got.reply      = o_reply_value;
                got.temp       = o_temperature;
                got.sens_range = o_sensor_range;
                got.resync     = o_resync_needed;
                if (expected_beats.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result beat: %s", beat_str(got));
                end else begin
                    want = expected_beats.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  expected %s", beat_str(want));
                            $display("  actual   %s", beat_str(got));
                        end
                    end
                end
                if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
                rx_hold = draw_wait(rx_quiet);
            end
            if (i_valid && !o_stall) begin
                next_item.op   = i_opcode;
                next_item.code = i_command_code;
                next_item.data = i_rx_byte;
                step_sensor_link(next_item);
                in_beat_taken = 1'b1;
            end
        end
    end

    // Stimulus, reset and final verdict
    initial begin
        int          txn;
        int          r;
        logic [3:0]  code;
        logic [7:0]  hi_b;
        logic [7:0]  lo_b;
        t_frame_flaw flaw;

        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_opcode       = ccfe_pkg::OP_START;
        i_command_code = ccfe_pkg::CMD_PPM;
        i_rx_byte      = 8'd0;
        i_stall        = 1'b0;
        drv_wait       = 0;
        drv_quiet      = 1'b0;
        rx_hold        = 0;
        rx_quiet       = 1'b0;
        in_beat_taken  = 1'b0;
        mismatch_cnt   = 0;
        pend_cmd       = ccfe_pkg::CMD_PPM;
        rx_count       = 4'd0;
        rx_sum         = 8'd0;
        header_ok      = 1'b0;
        payload_kept   = '{default: 8'd0};
        range_kept     = ccfe_pkg::RANGE_5000;
        temp_kept      = '0;
        resync_kept    = 1'b1;

        // Directed: reply before any request, every command code, ignored codes,
        // a request cutting into a reply
        queue_reply_frame(8'h00, 8'hFF, 8'hFF, 8'h00, FRAME_GOOD);
        for (int c = 0; c < ccfe_pkg::NUM_CODES; c++) queue_start(4'(c));
        queue_start(4'd9);
        queue_start(4'd15);
        queue_rx(ccfe_pkg::HEADER_BYTE);
        queue_rx(8'h00);
        queue_rx(8'hFF);
        queue_start(ccfe_pkg::CMD_TEMP);

        // Random: mostly command and reply exchanges, some broken or noisy traffic
        txn = 0;
        while (link_items.size() < 140) begin
            r = $urandom_range(0, 99);
            code = (txn < ccfe_pkg::NUM_CODES) ? 4'(txn)
                 : 4'($urandom_range(0, ccfe_pkg::NUM_CODES - 1));
            if (txn < ccfe_pkg::NUM_CODES || r < 70) begin
                if (txn < ccfe_pkg::NUM_CODES || r >= 8) queue_start(code);
                r = $urandom_range(0, 9);
                if (r < 8)       flaw = FRAME_GOOD;
                else if (r == 8) flaw = FRAME_BAD_HEADER;
                else             flaw = FRAME_BAD_SUM;
                hi_b = rand_byte();
                lo_b = rand_byte();
                if ($urandom_range(0, 4) == 0) begin
                    hi_b = 8'h00;
                    lo_b = 8'h00;
                end
                queue_reply_frame(rand_byte(), rand_byte(), hi_b, lo_b, flaw);
            end else if (r < 80) begin
                queue_start(code);
                repeat ($urandom_range(1, ccfe_pkg::FRAME_LEN - 1)) queue_rx(rand_byte());
                queue_start(4'($urandom_range(0, ccfe_pkg::NUM_CODES - 1)));
            end else if (r < 88) begin
                repeat ($urandom_range(1, 12)) queue_rx(rand_byte());
                if ($urandom_range(0, 3) != 0) queue_start(code);
            end else if (r < 94) begin
                queue_start(4'($urandom_range(ccfe_pkg::NUM_CODES, 15)));
            end else begin
                queue_start(code);
            end
            txn++;
        end

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain stimulus, then outstanding beats, then let the pipeline settle
        while (link_items.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
